// File: sv/pfs_pkg.sv
// Package: shared word types, character codes and scan phase codes for the format scanner.
package pfs_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_word_t;

    typedef struct packed {
        logic       type_found;
        logic [1:0] arg_type;
        logic       end_of_string;
    } out_word_t;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_TEXT    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_PERCENT = 4'd1;
    localparam logic [PHASE_W-1:0] PH_FLAGS   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_WDIGITS = 4'd3;
    localparam logic [PHASE_W-1:0] PH_PREC    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_DOT     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PDIGITS = 4'd6;
    localparam logic [PHASE_W-1:0] PH_LENGTH  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_AFTER_H = 4'd8;
    localparam logic [PHASE_W-1:0] PH_AFTER_L = 4'd9;
    localparam logic [PHASE_W-1:0] PH_CONV    = 4'd10;

    localparam logic [1:0] TY_INT32   = 2'd0;
    localparam logic [1:0] TY_INT64   = 2'd1;
    localparam logic [1:0] TY_DOUBLE  = 2'd2;
    localparam logic [1:0] TY_POINTER = 2'd3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_L   = 8'h6C;
    localparam logic [7:0] CH_UP_L    = 8'h4C;
    localparam logic [7:0] CH_LOW_Q   = 8'h71;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_LOW_J   = 8'h6A;
    localparam logic [7:0] CH_LOW_T   = 8'h74;

    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_I   = 8'h69;
    localparam logic [7:0] CH_LOW_O   = 8'h6F;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LOW_E   = 8'h65;
    localparam logic [7:0] CH_UP_E    = 8'h45;
    localparam logic [7:0] CH_LOW_G   = 8'h67;
    localparam logic [7:0] CH_UP_G    = 8'h47;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_LOW_S   = 8'h73;
    localparam logic [7:0] CH_LOW_P   = 8'h70;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;

    // Longest fall-through chain is percent, flags, precision, length, conversion.
    localparam int SCAN_STEPS = 6;

endpackage

// File: sv/pfs_scan.sv
// Scan phase register and next-phase logic: one format byte per step.
module pfs_scan (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  pfs_pkg::in_word_t  word_in,
    output logic               emit,
    output pfs_pkg::out_word_t word_out
);
    import pfs_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               long_reg;
    logic               long_next;

    logic [PHASE_W-1:0] ph;
    logic               lng;
    logic               done;
    logic               found;
    logic [1:0]         ty;
    logic [7:0]         c;
    logic               is_digit;
    logic               is_flag;

    assign c        = word_in.char_code;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_flag  = c inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_ZERO, CH_HASH, CH_QUOTE};

    always_comb begin
        ph    = phase_reg;
        lng   = long_reg;
        done  = 1'b0;
        found = 1'b0;
        ty    = TY_INT32;
        for (int i = 0; i < SCAN_STEPS; i++) begin
            if (!done) begin
                case (ph)
                    PH_PERCENT: begin
                        if (c == CH_PERCENT) begin
                            ph   = PH_TEXT;
                            done = 1'b1;
                        end else begin
                            ph = PH_FLAGS;
                        end
                    end
                    PH_FLAGS: begin
                        if (is_flag) begin
                            done = 1'b1;
                        end else if (c == CH_STAR) begin
                            found = 1'b1;
                            ty    = TY_INT32;
                            ph    = PH_PREC;
                            done  = 1'b1;
                        end else if (is_digit) begin
                            ph   = PH_WDIGITS;
                            done = 1'b1;
                        end else begin
                            ph = PH_PREC;
                        end
                    end
                    PH_WDIGITS: begin
                        if (is_digit) begin
                            done = 1'b1;
                        end else begin
                            ph = PH_PREC;
                        end
                    end
                    PH_PREC: begin
                        if (c == CH_DOT) begin
                            ph   = PH_DOT;
                            done = 1'b1;
                        end else begin
                            ph = PH_LENGTH;
                        end
                    end
                    PH_DOT: begin
                        if (c == CH_STAR) begin
                            found = 1'b1;
                            ty    = TY_INT32;
                            ph    = PH_LENGTH;
                            done  = 1'b1;
                        end else if (is_digit) begin
                            ph   = PH_PDIGITS;
                            done = 1'b1;
                        end else begin
                            ph = PH_LENGTH;
                        end
                    end
                    PH_PDIGITS: begin
                        if (is_digit) begin
                            done = 1'b1;
                        end else begin
                            ph = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        if (c == CH_LOW_H) begin
                            ph   = PH_AFTER_H;
                            done = 1'b1;
                        end else if (c == CH_LOW_L) begin
                            lng  = 1'b1;
                            ph   = PH_AFTER_L;
                            done = 1'b1;
                        end else if (c inside {CH_UP_L, CH_LOW_Q, CH_LOW_Z, CH_LOW_J,
                                               CH_LOW_T}) begin
                            lng  = 1'b1;
                            ph   = PH_CONV;
                            done = 1'b1;
                        end else begin
                            ph = PH_CONV;
                        end
                    end
                    PH_AFTER_H: begin
                        ph = PH_CONV;
                        if (c == CH_LOW_H) begin
                            done = 1'b1;
                        end
                    end
                    PH_AFTER_L: begin
                        ph = PH_CONV;
                        if (c == CH_LOW_L) begin
                            done = 1'b1;
                        end
                    end
                    PH_CONV: begin
                        if (c inside {CH_LOW_D, CH_LOW_I, CH_LOW_O, CH_LOW_U, CH_LOW_X,
                                      CH_UP_X, CH_LOW_C}) begin
                            found = 1'b1;
                            ty    = lng ? TY_INT64 : TY_INT32;
                        end else if (c inside {CH_LOW_F, CH_UP_F, CH_LOW_E, CH_UP_E,
                                               CH_LOW_G, CH_UP_G, CH_LOW_A, CH_UP_A}) begin
                            found = 1'b1;
                            ty    = TY_DOUBLE;
                        end else if (c inside {CH_LOW_S, CH_LOW_P, CH_LOW_N}) begin
                            found = 1'b1;
                            ty    = TY_POINTER;
                        end
                        lng  = 1'b0;
                        ph   = PH_TEXT;
                        done = 1'b1;
                    end
                    default: begin
                        if (c == CH_PERCENT) begin
                            lng = 1'b0;
                            ph  = PH_PERCENT;
                        end else begin
                            ph = PH_TEXT;
                        end
                        done = 1'b1;
                    end
                endcase
            end
        end

        if (word_in.last_char) begin
            phase_next = PH_TEXT;
            long_next  = 1'b0;
        end else begin
            phase_next = ph;
            long_next  = lng;
        end
    end

    assign emit                   = found || word_in.last_char;
    assign word_out.type_found    = found;
    assign word_out.arg_type      = found ? ty : TY_INT32;
    assign word_out.end_of_string = word_in.last_char;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TEXT;
            long_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            long_reg  <= long_next;
        end
    end

endmodule

// File: sv/printf_format_arg_type_scanner.sv
// Top level: input register, format scan logic and result register.
//
//  channel | ports                    | word
//  --------+--------------------------+----------------------------------------------
//  input   | s_valid s_ready s_data   | char_code, last_char
//  result  | m_valid m_ready m_data   | type_found, arg_type, end_of_string
//
// One word per cycle unless a result must wait; each byte and each result is registered.
// Throughput is set by the single phase register, updated once per byte.
// Synchronous active-low reset returns the scanner to plain text and empties both registers.
// A stalled result holds; bytes that give no result keep flowing until one needs the result
// register while it is still full.
module printf_format_arg_type_scanner (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pfs_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pfs_pkg::out_word_t m_data
);
    import pfs_pkg::*;

    logic      in_valid_reg;
    in_word_t  in_data_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;

    logic      emit;
    out_word_t scan_word;
    logic      out_free;
    logic      advance;

    pfs_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .word_in  (in_data_reg),
        .emit     (emit),
        .word_out (scan_word)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!emit || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_data_reg <= scan_word;
        end
    end

`ifndef SYNTHESIS
    a_no_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.type_found || m_data.end_of_string))
        else $error("result word carries neither a type nor end of string");

    a_type_zero_when_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.type_found) |-> (m_data.arg_type == TY_INT32))
        else $error("arg_type set without a type");

    a_held_byte_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("held input byte changed");

    a_full_output_blocks_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && in_valid_reg && emit) |-> !advance)
        else $error("result overwritten while stalled");
`endif

endmodule

// File: tb/printf_format_arg_type_scanner_tb.sv
// Testbench for printf_format_arg_type_scanner: format strings in, checked argument types out.
module printf_format_arg_type_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfs_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_data;

    logic [PHASE_W-1:0] spec_phase;
    bit                 long_mod;

    out_word_t  expected_words[$];
    logic [7:0] fmt_buf[$];
    logic [7:0] conv_set[$];
    logic [7:0] flag_set[$];
    logic [7:0] len_set[$];

    bit tx_idle_on;
    bit rx_idle_on;
    int errors;
    int bytes_sent;
    int strings_sent;
    int words_checked;
    int end_only;
    int type_seen[4];
    int quiet_cycles;

    printf_format_arg_type_scanner i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Walks the specifier phases for one byte; returns 1 when a result word is due.
    function automatic bit predict_word(input in_word_t w, output out_word_t want);
        logic [7:0] c;
        logic [1:0] ty;
        bit         settled;
        bit         hit;
        c = w.char_code;
        ty = TY_INT32;
        hit = 1'b0;
        settled = 1'b0;
        while (!settled) begin
            settled = 1'b1;
            case (spec_phase)
                PH_PERCENT: begin
                    if (c == CH_PERCENT) begin
                        spec_phase = PH_TEXT;
                    end else begin
                        spec_phase = PH_FLAGS;
                        settled = 1'b0;
                    end
                end
                PH_FLAGS: begin
                    if (c == CH_MINUS || c == CH_PLUS || c == CH_SPACE || c == CH_ZERO ||
                        c == CH_HASH || c == CH_QUOTE) begin
                        spec_phase = PH_FLAGS;
                    end else if (c == CH_STAR) begin
                        hit = 1'b1;
                        ty = TY_INT32;
                        spec_phase = PH_PREC;
                    end else if (is_digit(c)) begin
                        spec_phase = PH_WDIGITS;
                    end else begin
                        spec_phase = PH_PREC;
                        settled = 1'b0;
                    end
                end
                PH_WDIGITS: begin
                    if (!is_digit(c)) begin
                        spec_phase = PH_PREC;
                        settled = 1'b0;
                    end
                end
                PH_PREC: begin
                    if (c == CH_DOT) begin
                        spec_phase = PH_DOT;
                    end else begin
                        spec_phase = PH_LENGTH;
                        settled = 1'b0;
                    end
                end
                PH_DOT: begin
                    if (c == CH_STAR) begin
                        hit = 1'b1;
                        ty = TY_INT32;
                        spec_phase = PH_LENGTH;
                    end else if (is_digit(c)) begin
                        spec_phase = PH_PDIGITS;
                    end else begin
                        spec_phase = PH_LENGTH;
                        settled = 1'b0;
                    end
                end
                PH_PDIGITS: begin
                    if (!is_digit(c)) begin
                        spec_phase = PH_LENGTH;
                        settled = 1'b0;
                    end
                end
                PH_LENGTH: begin
                    if (c == CH_LOW_H) begin
                        spec_phase = PH_AFTER_H;
                    end else if (c == CH_LOW_L) begin
                        long_mod = 1'b1;
                        spec_phase = PH_AFTER_L;
                    end else if (c == CH_UP_L || c == CH_LOW_Q || c == CH_LOW_Z ||
                                 c == CH_LOW_J || c == CH_LOW_T) begin
                        long_mod = 1'b1;
                        spec_phase = PH_CONV;
                    end else begin
                        spec_phase = PH_CONV;
                        settled = 1'b0;
                    end
                end
                PH_AFTER_H: begin
                    spec_phase = PH_CONV;
                    settled = (c == CH_LOW_H);
                end
                PH_AFTER_L: begin
                    spec_phase = PH_CONV;
                    settled = (c == CH_LOW_L);
                end
                PH_CONV: begin
                    case (c)
                        CH_LOW_D, CH_LOW_I, CH_LOW_O, CH_LOW_U, CH_LOW_X, CH_UP_X,
                        CH_LOW_C: begin
                            hit = 1'b1;
                            ty = long_mod ? TY_INT64 : TY_INT32;
                        end
                        CH_LOW_F, CH_UP_F, CH_LOW_E, CH_UP_E, CH_LOW_G, CH_UP_G,
                        CH_LOW_A, CH_UP_A: begin
                            hit = 1'b1;
                            ty = TY_DOUBLE;
                        end
                        CH_LOW_S, CH_LOW_P, CH_LOW_N: begin
                            hit = 1'b1;
                            ty = TY_POINTER;
                        end
                        default: hit = 1'b0;
                    endcase
                    long_mod = 1'b0;
                    spec_phase = PH_TEXT;
                end
                default: begin
                    if (c == CH_PERCENT) begin
                        long_mod = 1'b0;
                        spec_phase = PH_PERCENT;
                    end else begin
                        spec_phase = PH_TEXT;
                    end
                end
            endcase
        end
        if (w.last_char) begin
            spec_phase = PH_TEXT;
            long_mod = 1'b0;
        end
        want.type_found = hit;
        want.arg_type = hit ? ty : TY_INT32;
        want.end_of_string = w.last_char;
        return hit || w.last_char;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        fmt_buf.insert(fmt_buf.size(), b);
    endtask

    task automatic send_byte(input logic [7:0] c, input logic is_last);
        in_word_t  w;
        out_word_t want;
        w = '{char_code: c, last_char: is_last};
        @(negedge aclk);
        if (tx_idle_on && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < 32);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        if (predict_word(w, want))
            expected_words.insert(expected_words.size(), want);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < fmt_buf.size(); i++)
            send_byte(fmt_buf[i], i == fmt_buf.size() - 1);
        strings_sent++;
        fmt_buf.delete();
    endtask

    // Holds the sender off until every expected word has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // cut: stop before the conversion byte, leaving the specifier open
    task automatic add_spec(input bit cut);
        int n;
        put_byte(CH_PERCENT);
        if (!cut && $urandom_range(9) == 0) begin
            put_byte(CH_PERCENT);
            return;
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) put_byte(flag_set[$urandom_range(flag_set.size() - 1)]);
        case ($urandom_range(3))
            0: ;
            1: put_byte(CH_STAR);
            default: repeat ($urandom_range(1, 3)) put_byte(8'(CH_ZERO + $urandom_range(9)));
        endcase
        if ($urandom_range(2) == 0) begin
            put_byte(CH_DOT);
            if ($urandom_range(1))
                put_byte(CH_STAR);
            else
                repeat ($urandom_range(2)) put_byte(8'(CH_ZERO + $urandom_range(9)));
        end
        case ($urandom_range(9))
            0, 1, 2, 3: ;
            4: repeat (2) put_byte(CH_LOW_H);
            5: repeat (2) put_byte(CH_LOW_L);
            default: put_byte(len_set[$urandom_range(len_set.size() - 1)]);
        endcase
        if (cut)
            return;
        if ($urandom_range(15) == 0)
            put_byte(8'($urandom_range(255)));
        else
            put_byte(conv_set[$urandom_range(conv_set.size() - 1)]);
    endtask

    // noisy text leans on percent signs and format letters to break specifiers
    task automatic add_text(input bit noisy);
        repeat ($urandom_range(1, 4)) begin
            case (noisy ? $urandom_range(3) : 3)
                0: put_byte(CH_PERCENT);
                1: put_byte(conv_set[$urandom_range(conv_set.size() - 1)]);
                2: put_byte(flag_set[$urandom_range(flag_set.size() - 1)]);
                default: put_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    task automatic send_random_strings(input int n_bytes, input int text_pct, input bit noisy);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(99) < text_pct)
                    add_text(noisy);
                else
                    add_spec(1'b0);
            end
            if ($urandom_range(4) == 0)
                add_spec(1'b1);
            send_string();
        end
    endtask

    task automatic test_directed();
        fmt_buf = '{8'h00, 8'hFF, CH_PERCENT, CH_PERCENT};
        send_string();
        fmt_buf = '{CH_PERCENT, CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_QUOTE, CH_ZERO,
                    CH_STAR, CH_DOT, CH_STAR, CH_LOW_L, CH_LOW_L, CH_LOW_D};
        send_string();
        fmt_buf = '{CH_PERCENT, CH_LOW_H, CH_LOW_H, CH_LOW_P};
        send_string();
        // unknown conversion letter, then a percent cut off by the end of string
        fmt_buf = '{CH_PERCENT, CH_LOW_Z, 8'h6B, CH_PERCENT};
        send_string();
    endtask

    task automatic test_specifiers();
        send_random_strings(430, 20, 1'b0);
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_strings(150, 20, 1'b0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_noise();
        send_random_strings(190, 60, 1'b1);
    endtask

    task automatic check_word(input out_word_t got);
        out_word_t want;
        string     what;
        words_checked++;
        if (got.type_found)
            type_seen[got.arg_type]++;
        else
            end_only++;
        if (expected_words.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%t unexpected word: found=%0d type=%0d end=%0d", $realtime,
                         got.type_found, got.arg_type, got.end_of_string);
            return;
        end
        want = expected_words.pop_front();
        what = "";
        if (got.type_found !== want.type_found)
            what = {what, " type_found"};
        if (got.arg_type !== want.arg_type)
            what = {what, " arg_type"};
        if (got.end_of_string !== want.end_of_string)
            what = {what, " end_of_string"};
        if (what != "") begin
            errors++;
            if (errors <= 10)
                $display("%t mismatch in%s: want found=%0d type=%0d end=%0d, got %0d %0d %0d",
                         $realtime, what, want.type_found, want.arg_type, want.end_of_string,
                         got.type_found, got.arg_type, got.end_of_string);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_word(m_data);
    end

    always @(negedge aclk) begin
        m_ready <= !(rx_idle_on && $urandom_range(99) < 32);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%t timeout: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        quiet_cycles = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        spec_phase = PH_TEXT;
        long_mod = 1'b0;
        conv_set = '{CH_LOW_D, CH_LOW_I, CH_LOW_O, CH_LOW_U, CH_LOW_X, CH_UP_X, CH_LOW_C,
                     CH_LOW_F, CH_UP_F, CH_LOW_E, CH_UP_E, CH_LOW_G, CH_UP_G, CH_LOW_A,
                     CH_UP_A, CH_LOW_S, CH_LOW_P, CH_LOW_N};
        flag_set = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_ZERO, CH_HASH, CH_QUOTE};
        len_set = '{CH_LOW_H, CH_LOW_L, CH_UP_L, CH_LOW_Q, CH_LOW_Z, CH_LOW_J, CH_LOW_T};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        drain();
        test_specifiers();
        drain();
        test_back_to_back();
        drain();
        test_noise();
        drain();
        repeat (10) @(posedge aclk);

        errors += expected_words.size();
        $display("%0d bytes in %0d strings, %0d result words checked", bytes_sent,
                 strings_sent, words_checked);
        $display("int32 %0d, int64 %0d, double %0d, pointer %0d, end with no type %0d",
                 type_seen[TY_INT32], type_seen[TY_INT64], type_seen[TY_DOUBLE],
                 type_seen[TY_POINTER], end_only);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
sv/pfs_pkg.sv
sv/pfs_scan.sv
sv/printf_format_arg_type_scanner.sv
tb/printf_format_arg_type_scanner_tb.sv
